@@ rtl/core/b64u_pkg.sv @@
// Package with the sextet type and the character decode function for the Base64URL decoder.
`default_nettype none

package b64u_pkg;

  // One decoded character: valid flag and six-bit value.
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Position of a character within its four-character group.
  typedef logic [1:0] group_pos_t;

  localparam group_pos_t POS_FIRST  = 2'd0;
  localparam group_pos_t POS_SECOND = 2'd1;
  localparam group_pos_t POS_THIRD  = 2'd2;
  localparam group_pos_t POS_FOURTH = 2'd3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_UNDER   = 8'h5F;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  localparam logic [5:0] SEXTET_62   = 6'd62;
  localparam logic [5:0] SEXTET_63   = 6'd63;
  localparam logic [5:0] LOWER_BASE  = 6'd26;
  localparam logic [5:0] DIGIT_BASE  = 6'd52;

  // Maps a raw character to its sextet; anything outside both alphabets is invalid.
  function automatic sextet_t decode_char(input logic [7:0] c);
    sextet_t s;
    logic [7:0] d;
    s = '0;
    d = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
      s = '{ok: 1'b1, val: d[5:0]};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A;
      s = '{ok: 1'b1, val: d[5:0] + LOWER_BASE};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d = c - CHAR_DIGIT_0;
      s = '{ok: 1'b1, val: d[5:0] + DIGIT_BASE};
    end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
      s = '{ok: 1'b1, val: SEXTET_62};
    end else if (c == CHAR_UNDER || c == CHAR_SLASH) begin
      s = '{ok: 1'b1, val: SEXTET_63};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/base64url_decoder_top.sv @@
// Top level of the Base64URL decoder: one character in, at most one byte out per item.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------------
//   input   | in_valid / in_ready  | char_code[7:0], is_last
//   output  | out_valid / out_ready| data_byte[7:0], data_valid, end_of_stream,
//           |                      | bad_encoding
//
// The decode and byte assembly sit between the group state and a single result register,
// so one item is accepted per cycle while the output is not stalled.
// A result appears on the output in the cycle after its item is accepted.
// The input is taken whenever the result register is empty or is being emptied.
// Synchronous reset clears the group position, the sextet valid bits and the error flag.
`default_nettype none

module base64url_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       is_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      data_byte,
  output logic            data_valid,
  output logic            end_of_stream,
  output logic            bad_encoding
);

  import b64u_pkg::*;

  group_pos_t group_position;
  group_pos_t group_position_next;
  sextet_t    first_sextet;
  sextet_t    second_sextet;
  sextet_t    third_sextet;
  logic       error_seen;

  sextet_t    cur;
  logic       accept;
  logic       err;
  logic       emit;
  logic [7:0] byte_val;
  logic [5:0] third_val;
  logic       produce;

  // The result register is free when empty or when its item leaves this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign cur      = decode_char(char_code);

  assign group_position_next = group_position + 2'd1;

  // Byte assembly for the current group position.
  always_comb begin
    err       = error_seen;
    emit      = 1'b0;
    byte_val  = '0;
    third_val = third_sextet.ok ? third_sextet.val : SEXTET_63;
    unique case (group_position)
      POS_FIRST: begin
        if (is_last) begin
          err = 1'b1;
        end
      end
      POS_SECOND: begin
        if (!first_sextet.ok || !cur.ok) begin
          err = 1'b1;
        end else begin
          byte_val = {first_sextet.val, cur.val[5:4]};
          emit     = 1'b1;
        end
      end
      POS_THIRD: begin
        if (cur.ok) begin
          byte_val = {second_sextet.val[3:0], cur.val[5:2]};
          emit     = 1'b1;
        end
      end
      POS_FOURTH: begin
        if (cur.ok) begin
          byte_val = {third_val[1:0], cur.val};
          emit     = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (err) begin
      emit = 1'b0;
    end
  end

  // A result leaves for every decoded byte and always for the final character.
  assign produce = emit || is_last;

  // Group state; the final character returns everything to its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= POS_FIRST;
      first_sextet   <= '0;
      second_sextet  <= '0;
      third_sextet   <= '0;
      error_seen     <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        group_position <= POS_FIRST;
        first_sextet   <= '0;
        second_sextet  <= '0;
        third_sextet   <= '0;
        error_seen     <= 1'b0;
      end else begin
        group_position <= group_position_next;
        error_seen     <= err;
        unique case (group_position)
          POS_FIRST:  first_sextet  <= cur;
          POS_SECOND: second_sextet <= cur;
          POS_THIRD:  third_sextet  <= cur;
          default:    third_sextet  <= third_sextet;
        endcase
      end
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      data_byte     <= emit ? byte_val : 8'd0;
      data_valid    <= emit;
      end_of_stream <= is_last;
      bad_encoding  <= is_last && err;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_base64url_decoder_top.sv @@
// Self-checking testbench for the Base64URL decoder: random strings, bursty input, stalled output.
`default_nettype none

module tb_base64url_decoder_top;
  import b64u_pkg::*;

  localparam int         RANDOM_CHARS = 950;
  localparam int         IDLE_LIMIT   = 2000;
  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] STAR_CHAR    = 8'h2A;

  // One character waiting to be sent, optionally held until all bytes are out.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       drain;
  } char_item_t;

  // One decoded result as the block should present it.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       valid;
    logic       eos;
    logic       bad;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = 8'h00;
  logic       is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       end_of_stream;
  logic       bad_encoding;

  char_item_t char_queue[$];
  decoded_t   owed_bytes[$];
  int         errors = 0;
  logic       in_taken = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         rcv_cycle = 0;
  int         idle_cycles = 0;

  // Decoder state mirrored by the predictor.
  group_pos_t grp_pos = POS_FIRST;
  sextet_t    sx_first = '0;
  sextet_t    sx_second = '0;
  sextet_t    sx_third = '0;
  logic       err_flag = 1'b0;

  base64url_decoder_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_byte     (data_byte),
    .data_valid    (data_valid),
    .end_of_stream (end_of_stream),
    .bad_encoding  (bad_encoding)
  );

  always #5 clk = ~clk;

  // Maps a character to its six-bit value; the ok flag stays clear outside both alphabets.
  function automatic sextet_t char_to_sextet(input logic [7:0] c);
    sextet_t s;
    logic [7:0] off;
    s = '0;
    off = 8'h00;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      off = c - CHAR_UPPER_A;
      s.ok = 1'b1;
      s.val = off[5:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      off = c - CHAR_LOWER_A + 8'd26;
      s.ok = 1'b1;
      s.val = off[5:0];
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      off = c - CHAR_DIGIT_0 + 8'd52;
      s.ok = 1'b1;
      s.val = off[5:0];
    end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
      s.ok = 1'b1;
      s.val = 6'd62;
    end else if (c == CHAR_UNDER || c == CHAR_SLASH) begin
      s.ok = 1'b1;
      s.val = 6'd63;
    end
    return s;
  endfunction

  // Advances the mirrored decoder by one character and records the byte it owes, if any.
  task automatic decode_char_step(input logic [7:0] c, input logic last);
    sextet_t    s;
    logic [7:0] b;
    logic [5:0] hi;
    logic       emit;
    logic       err;
    s = char_to_sextet(c);
    b = 8'h00;
    emit = 1'b0;
    err = err_flag;
    case (grp_pos)
      POS_FIRST: begin
        sx_first = s;
        if (last) err = 1'b1;
      end
      POS_SECOND: begin
        sx_second = s;
        if (!sx_first.ok || !s.ok) begin
          err = 1'b1;
        end else begin
          b = {sx_first.val, s.val[5:4]};
          emit = 1'b1;
        end
      end
      POS_THIRD: begin
        sx_third = s;
        if (s.ok) begin
          b = {sx_second.val[3:0], s.val[5:2]};
          emit = 1'b1;
        end
      end
      default: begin
        // A skipped third character counts as all ones.
        if (s.ok) begin
          hi = sx_third.ok ? sx_third.val : 6'h3F;
          b = {hi[1:0], s.val};
          emit = 1'b1;
        end
      end
    endcase
    grp_pos = grp_pos + 2'd1;
    if (err) emit = 1'b0;
    err_flag = err;
    if (last) begin
      owed_bytes.insert(owed_bytes.size(), decoded_t'{emit ? b : 8'h00, emit, 1'b1, err});
      grp_pos = POS_FIRST;
      sx_first = '0;
      sx_second = '0;
      sx_third = '0;
      err_flag = 1'b0;
    end else if (emit) begin
      owed_bytes.insert(owed_bytes.size(), decoded_t'{b, 1'b1, 1'b0, 1'b0});
    end
  endtask

  task automatic add_char(input logic [7:0] c, input logic last, input logic drain);
    char_queue.insert(char_queue.size(), char_item_t'{c, last, drain});
  endtask

  // Picks a character from either alphabet.
  function automatic logic [7:0] alphabet_char();
    int r;
    r = $urandom_range(0, 65);
    if (r < 26) return CHAR_UPPER_A + 8'(r);
    if (r < 52) return CHAR_LOWER_A + 8'(r - 26);
    if (r < 62) return CHAR_DIGIT_0 + 8'(r - 52);
    case (r)
      62: return CHAR_MINUS;
      63: return CHAR_UNDER;
      64: return CHAR_PLUS;
      default: return CHAR_SLASH;
    endcase
  endfunction

  // Stimulus: directed strings, then random strings, then the final drain and verdict.
  initial begin
    int         n;
    int         len;
    int         mode;
    int         next_drain;
    logic [7:0] c;
    logic       drain;

    // Plain group, then both alternative alphabets.
    add_char("T", 1'b0, 1'b0);
    add_char("W", 1'b0, 1'b0);
    add_char("F", 1'b0, 1'b0);
    add_char("u", 1'b1, 1'b0);
    add_char(CHAR_MINUS, 1'b0, 1'b0);
    add_char(CHAR_UNDER, 1'b0, 1'b0);
    add_char(CHAR_PLUS, 1'b0, 1'b0);
    add_char(CHAR_SLASH, 1'b1, 1'b0);
    // Byte emitted on the last character itself.
    add_char("A", 1'b0, 1'b0);
    add_char("A", 1'b1, 1'b0);
    // Dangling single character.
    add_char("Z", 1'b1, 1'b0);
    // Padding in the leading pair.
    add_char(PAD_CHAR, 1'b0, 1'b0);
    add_char("9", 1'b1, 1'b0);
    // Invalid third character before a valid fourth.
    add_char("a", 1'b0, 1'b0);
    add_char("z", 1'b0, 1'b0);
    add_char(8'hFF, 1'b0, 1'b0);
    add_char("9", 1'b1, 1'b0);
    // Sticky error: nothing more is emitted after a bad leading pair.
    add_char(8'h00, 1'b0, 1'b0);
    add_char("A", 1'b0, 1'b0);
    add_char("A", 1'b0, 1'b0);
    add_char("A", 1'b0, 1'b0);
    add_char(STAR_CHAR, 1'b1, 1'b0);

    // Random strings: mostly clean, some with stray characters, some pure noise.
    n = 0;
    next_drain = 300;
    while (n < RANDOM_CHARS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      mode = $urandom_range(0, 9);
      drain = 1'b0;
      if (n >= next_drain) begin
        drain = 1'b1;
        next_drain += 300;
      end
      for (int i = 0; i < len; i++) begin
        if (mode < 7) begin
          c = alphabet_char();
          if (i >= len - 2 && len % 4 != 1 && $urandom_range(0, 4) == 0) c = PAD_CHAR;
        end else if (mode < 9) begin
          c = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : alphabet_char();
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        add_char(c, i == len - 1, drain && i == 0);
        n++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (char_queue.size() > 0 || in_valid) @(posedge clk);
    while (owed_bytes.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (owed_bytes.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, owed_bytes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_base64url_decoder_top OK");
    end else begin
      $display("tb_base64url_decoder_top NOT OK");
    end
    $finish;
  end

  // Sender: bursts of items with random gaps; a marked item waits for all owed bytes.
  always @(negedge clk) begin
    char_item_t nx;
    logic       nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (char_queue.size() > 0 &&
                   (!char_queue[0].drain || owed_bytes.size() == 0)) begin
        nx = char_queue.pop_front();
        nv = 1'b1;
        char_code <= nx.code;
        is_last <= nx.last;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_valid <= nv;
    end
  end

  // Receiver: the stall pattern rotates through four modes.
  always @(negedge clk) begin
    rcv_cycle++;
    case ((rcv_cycle / 97) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((rcv_cycle % 7) < 3);
    endcase
  end

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk) begin
    decoded_t exp_r;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (owed_bytes.size() == 0) begin
          $display("%0t: unexpected result byte=%02h valid=%b eos=%b bad=%b", $time,
                   data_byte, data_valid, end_of_stream, bad_encoding);
          errors++;
        end else begin
          exp_r = owed_bytes.pop_front();
          if (data_byte !== exp_r.byte_val) begin
            $display("%0t: data_byte expected %02h actual %02h", $time, exp_r.byte_val,
                     data_byte);
            errors++;
          end
          if (data_valid !== exp_r.valid) begin
            $display("%0t: data_valid expected %b actual %b", $time, exp_r.valid, data_valid);
            errors++;
          end
          if (end_of_stream !== exp_r.eos) begin
            $display("%0t: end_of_stream expected %b actual %b", $time, exp_r.eos,
                     end_of_stream);
            errors++;
          end
          if (bad_encoding !== exp_r.bad) begin
            $display("%0t: bad_encoding expected %b actual %b", $time, exp_r.bad,
                     bad_encoding);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) decode_char_step(char_code, is_last);
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_base64url_decoder_top NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/b64u_pkg.sv
rtl/core/base64url_decoder_top.sv
tb/tb_base64url_decoder_top.sv
